### rtl/fshh_pkg.sv
// ----------------------------------------------------------------------------
// fshh_pkg
// Shared sizes, types and helpers for the flow sketch heavy-hitter unit.
// ----------------------------------------------------------------------------
package fshh_pkg;

	// Address width of one IPv4 flow endpoint.
	localparam int ADDR_W = 32;

	// Counters per row. The row index keeps the low bits of each hash, so the
	// depth is a power of two.
	localparam int ROW_DEPTH = 1024;
	localparam int IDX_W = $clog2(ROW_DEPTH);

	// Counter width and the value at which a counter saturates.
	localparam int COUNT_WIDTH = 32;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [COUNT_WIDTH-1:0] count_t;

	localparam count_t COUNT_MAX = '1;

	// Control that the top level hands to each counter row.
	typedef struct packed {
		logic adv;     // pipeline moves on this cycle
		logic rd_en;   // a new flow is read in
		idx_t rd_idx;  // row index of the new flow
		logic upd;     // the flow in the first stage writes back
		logic clr_en;  // clearing pass writes zero
		idx_t clr_idx; // entry being cleared
	} row_ctrl_t;

	// Saturating increment of one counter.
	function automatic count_t sat_inc(input count_t v);
		count_t r;
		if (v == COUNT_MAX) begin
			r = v;
		end else begin
			r = v + count_t'(1);
		end
		return r;
	endfunction

endpackage

### rtl/fshh_flow_if.sv
// ----------------------------------------------------------------------------
// fshh_flow_if
// Request channel carrying one flow as a source and destination address.
// ----------------------------------------------------------------------------
interface fshh_flow_if import fshh_pkg::*;;
	logic valid;
	logic ready;
	addr_t src_addr;
	addr_t dst_addr;

	modport source (output valid, output src_addr, output dst_addr, input ready);
	modport sink (input valid, input src_addr, input dst_addr, output ready);
endinterface

### rtl/fshh_result_if.sv
// ----------------------------------------------------------------------------
// fshh_result_if
// Result channel carrying the flow estimate and the current heavy hitter.
// ----------------------------------------------------------------------------
interface fshh_result_if import fshh_pkg::*;;
	logic valid;
	logic ready;
	logic [31:0] estimate;
	logic new_leader;
	logic [31:0] leader_count;
	addr_t leader_src;
	addr_t leader_dst;

	modport source (output valid, output estimate, output new_leader,
		output leader_count, output leader_src, output leader_dst, input ready);
	modport sink (input valid, input estimate, input new_leader,
		input leader_count, input leader_src, input leader_dst, output ready);
endinterface

### rtl/fshh_ram.sv
// ----------------------------------------------------------------------------
// fshh_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module fshh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/fshh_row.sv
// ----------------------------------------------------------------------------
// fshh_row
// One counter row: memory, read-modify-write with forwarding, and saturation.
// ----------------------------------------------------------------------------
module fshh_row import fshh_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  row_ctrl_t ctrl,
	output count_t    cnt_s2
);

	idx_t   idx_s1;
	count_t rd_data;
	count_t cur;
	count_t nxt;
	logic   fwd_vld_q;
	idx_t   fwd_idx_q;
	count_t fwd_val_q;
	logic   we;
	idx_t   waddr;
	count_t wdata;

	// A write issued in the same cycle as this entry's read is not seen in
	// the read data, so it is taken from the forwarding register instead.
	assign cur = (fwd_vld_q && fwd_idx_q == idx_s1) ? fwd_val_q : rd_data;
	assign nxt = sat_inc(cur);

	// The clearing pass and the update share the single write port.
	assign we    = ctrl.clr_en | ctrl.upd;
	assign waddr = ctrl.clr_en ? ctrl.clr_idx : idx_s1;
	assign wdata = ctrl.clr_en ? '0 : nxt;

	fshh_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(ROW_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (ctrl.rd_en),
		.raddr (ctrl.rd_idx),
		.rdata (rd_data)
	);

	// Forwarding is armed by every update write as the pipeline moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
		end else if (ctrl.adv) begin
			fwd_vld_q <= ctrl.upd;
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			idx_s1    <= ctrl.rd_idx;
			fwd_idx_q <= idx_s1;
			fwd_val_q <= nxt;
			cnt_s2    <= nxt;
		end
	end

endmodule

### rtl/fshh_leader.sv
// ----------------------------------------------------------------------------
// fshh_leader
// Minimum of the three counters, heavy-hitter register and result register.
// ----------------------------------------------------------------------------
module fshh_leader import fshh_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   vld_s2,
	input  count_t cnt_a_s2,
	input  count_t cnt_b_s2,
	input  count_t cnt_c_s2,
	input  addr_t  src_s2,
	input  addr_t  dst_s2,
	output logic   adv,
	fshh_result_if.source result
);

	count_t est_ab;
	count_t est;
	logic   lead;
	count_t best_count_q;
	addr_t  best_src_q;
	addr_t  best_dst_q;
	logic   out_vld_q;
	count_t out_est_q;
	logic   out_lead_q;

	// The pipeline moves whenever the result register is free or being taken.
	assign adv = !out_vld_q || result.ready;

	// True minimum of the three updated counters, then the leader test.
	assign est_ab = (cnt_b_s2 < cnt_a_s2) ? cnt_b_s2 : cnt_a_s2;
	assign est    = (cnt_c_s2 < est_ab) ? cnt_c_s2 : est_ab;
	assign lead   = est > best_count_q;

	// Leader state and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_count_q <= '0;
			best_src_q   <= '0;
			best_dst_q   <= '0;
			out_vld_q    <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s2;
			if (vld_s2 && lead) begin
				best_count_q <= est;
				best_src_q   <= src_s2;
				best_dst_q   <= dst_s2;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (adv && vld_s2) begin
			out_est_q  <= est;
			out_lead_q <= lead;
		end
	end

	assign result.valid        = out_vld_q;
	assign result.estimate     = 32'(out_est_q);
	assign result.new_leader   = out_lead_q;
	assign result.leader_count = 32'(best_count_q);
	assign result.leader_src   = best_src_q;
	assign result.leader_dst   = best_dst_q;

	// The leader count never falls.
	a_best_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> best_count_q >= $past(best_count_q))
		else $error("leader count decreased");

	// A new leader carries its own estimate as the leader count.
	a_lead_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_lead_q |-> best_count_q == out_est_q)
		else $error("new leader without matching leader count");

	// A result that waits for the receiver stays unchanged.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !result.ready |=>
			out_vld_q && $stable(out_est_q) && $stable(best_count_q))
		else $error("waiting result changed");

endmodule

### rtl/flow_sketch_heavy_hitter_unit.sv
// ----------------------------------------------------------------------------
// flow_sketch_heavy_hitter_unit
// Count-min sketch of three counter rows with a single heavy-hitter register.
// ----------------------------------------------------------------------------
// Usage:
// A flow enters on the flow channel as a source and destination address and
// is accepted when valid and ready are both high. For every flow exactly one
// request leaves on the result channel: the minimum of its three updated
// counters, whether it became the heavy hitter, and the heavy hitter after
// the update. Results leave in the order the flows came in.
// An accepted flow moves through stages s1 and s2 into the result register,
// from which it can be taken. One flow is taken every cycle while no result
// waits on a stalled receiver; each row memory does one read and one write
// per cycle, and a write that meets a read of the same counter is forwarded.
// After reset the unit runs a clearing pass over all ROW_DEPTH entries that
// zeroes all counters; ready stays low until it ends. The leader is cleared
// at once. When a result waits and the receiver holds ready low, the whole
// pipeline holds and flow.ready drops, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module flow_sketch_heavy_hitter_unit import fshh_pkg::*; (
	input logic clk,
	input logic arst_n,
	fshh_flow_if.sink flow,
	fshh_result_if.source result
);

	logic      adv;
	logic      accept;
	logic      clearing_q;
	idx_t      clr_q;
	logic      vld_s1;
	logic      vld_s2;
	addr_t     src_s1;
	addr_t     dst_s1;
	addr_t     src_s2;
	addr_t     dst_s2;
	addr_t     h_sum;
	addr_t     h_diff;
	addr_t     h_xor;
	row_ctrl_t ctrl_sum;
	row_ctrl_t ctrl_diff;
	row_ctrl_t ctrl_xor;
	count_t    cnt_a_s2;
	count_t    cnt_b_s2;
	count_t    cnt_c_s2;

	assign flow.ready = adv && !clearing_q;
	assign accept     = flow.valid && flow.ready;

	// The three hashes of the address pair.
	assign h_sum  = flow.src_addr + flow.dst_addr;
	assign h_diff = flow.src_addr - flow.dst_addr;
	assign h_xor  = flow.src_addr ^ flow.dst_addr;

	// Row control; only the read index differs between rows.
	always_comb begin
		ctrl_sum.adv     = adv;
		ctrl_sum.rd_en   = accept;
		ctrl_sum.rd_idx  = h_sum[IDX_W-1:0];
		ctrl_sum.upd     = adv && vld_s1;
		ctrl_sum.clr_en  = clearing_q;
		ctrl_sum.clr_idx = clr_q;
		ctrl_diff        = ctrl_sum;
		ctrl_diff.rd_idx = h_diff[IDX_W-1:0];
		ctrl_xor         = ctrl_sum;
		ctrl_xor.rd_idx  = h_xor[IDX_W-1:0];
	end

	// Clearing pass after reset, one entry of every row per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + idx_t'(1);
			if (clr_q == idx_t'(ROW_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
		end
	end

	// Flow addresses travel alongside the counters.
	always_ff @(posedge clk) begin
		if (adv) begin
			src_s1 <= flow.src_addr;
			dst_s1 <= flow.dst_addr;
			src_s2 <= src_s1;
			dst_s2 <= dst_s1;
		end
	end

	fshh_row u_sum_row (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl_sum),
		.cnt_s2 (cnt_a_s2)
	);

	fshh_row u_diff_row (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl_diff),
		.cnt_s2 (cnt_b_s2)
	);

	fshh_row u_xor_row (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl_xor),
		.cnt_s2 (cnt_c_s2)
	);

	fshh_leader u_leader (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_s2   (vld_s2),
		.cnt_a_s2 (cnt_a_s2),
		.cnt_b_s2 (cnt_b_s2),
		.cnt_c_s2 (cnt_c_s2),
		.src_s2   (src_s2),
		.dst_s2   (dst_s2),
		.adv      (adv),
		.result   (result)
	);

	// No flow is taken while the counters are being cleared.
	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !accept)
		else $error("flow accepted during clearing pass");

	// An incremented counter is never zero, so neither is an estimate.
	a_est_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.estimate != 32'd0)
		else $error("zero estimate delivered");

	// A flow in the last stage reaches the result register when it moves.
	a_s2_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && adv |=> result.valid)
		else $error("flow lost between last stage and result");

endmodule

### test/flow_sketch_heavy_hitter_unit_tb.sv
// ----------------------------------------------------------------------------
// flow_sketch_heavy_hitter_unit_tb
// Self-checking bench for the flow sketch heavy-hitter unit. Flow requests are
// fed from a queue by a clocked driver with random gaps. A clocked monitor
// stalls the result channel at random. Each accepted flow updates a local
// copy of the three counter rows and the leader, and every result request is
// compared field by field with the oldest predicted report.
// ----------------------------------------------------------------------------
module flow_sketch_heavy_hitter_unit_tb;
	import fshh_pkg::*;

	localparam int CLK_PERIOD = 12;
	localparam int RESET_CYCLES = 6;
	// About 2000 flows with their random idle gaps, the clearing pass and the long
	// hold stay well inside the limit, which leaves ample margin.
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD_FLOWS = 60;
	localparam int PHASE_FLOWS = 310;
	localparam int HOT_FLOWS = 16;

	typedef struct {
		addr_t src;
		addr_t dst;
	} flow_t;

	typedef struct {
		count_t estimate;
		logic new_leader;
		count_t leader_count;
		addr_t leader_src;
		addr_t leader_dst;
	} flow_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	fshh_flow_if flow_ch();
	fshh_result_if result_ch();

	flow_sketch_heavy_hitter_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.flow(flow_ch),
		.result(result_ch)
	);

	// Local copy of the sketch and the heavy-hitter register.
	count_t sum_cnt [ROW_DEPTH];
	count_t diff_cnt [ROW_DEPTH];
	count_t xor_cnt [ROW_DEPTH];
	count_t lead_count;
	addr_t lead_src;
	addr_t lead_dst;

	flow_t pending_flows [$];
	flow_report_t report_q [$];
	flow_t hot_flows [HOT_FLOWS];

	int unsigned tx_gap_max;
	int unsigned rx_gap_max;
	int unsigned rx_holds_asked;
	int unsigned mismatch_count;
	int unsigned cycle_count = 0;

	// A counter steps up by one until it reaches its maximum, then stays there.
	function automatic count_t bumped(input count_t v);
		return (v == COUNT_MAX) ? v : v + count_t'(1);
	endfunction

	// Apply one flow to the sketch and queue the report it must produce.
	task automatic sketch_update(input addr_t src, input addr_t dst);
		idx_t sum_idx;
		idx_t diff_idx;
		idx_t xor_idx;
		count_t a;
		count_t b;
		count_t c;
		flow_report_t rep;
		sum_idx = idx_t'(src + dst);
		diff_idx = idx_t'(src - dst);
		xor_idx = idx_t'(src ^ dst);
		a = bumped(sum_cnt[sum_idx]);
		b = bumped(diff_cnt[diff_idx]);
		c = bumped(xor_cnt[xor_idx]);
		sum_cnt[sum_idx] = a;
		diff_cnt[diff_idx] = b;
		xor_cnt[xor_idx] = c;
		rep.estimate = a;
		if (b < rep.estimate) begin
			rep.estimate = b;
		end
		if (c < rep.estimate) begin
			rep.estimate = c;
		end
		// Only a strictly larger estimate takes the lead.
		rep.new_leader = 1'b0;
		if (rep.estimate > lead_count) begin
			lead_count = rep.estimate;
			lead_src = src;
			lead_dst = dst;
			rep.new_leader = 1'b1;
		end
		rep.leader_count = lead_count;
		rep.leader_src = lead_src;
		rep.leader_dst = lead_dst;
		report_q.push_back(rep);
	endtask

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
		end
	endtask

	task automatic queue_flow(input addr_t src, input addr_t dst);
		flow_t f;
		f.src = src;
		f.dst = dst;
		pending_flows.push_back(f);
	endtask

	// Half the flows come from a pool of recurring flows so that counters climb and
	// the leader changes hands; the rest are arbitrary flows and flows with colliding rows.
	function automatic flow_t random_flow();
		flow_t f;
		case ($urandom_range(3, 0))
			0, 1: begin
				f = hot_flows[$urandom_range(HOT_FLOWS - 1, 0)];
			end
			2: begin
				f.src = $urandom;
				f.dst = $urandom;
			end
			default: begin
				f.src = ($urandom_range(1, 0) ? 32'hFFFF_FFC0 : 32'h0) | $urandom_range(63, 0);
				f.dst = ($urandom_range(1, 0) ? 32'hFFFF_FFC0 : 32'h0) | $urandom_range(63, 0);
			end
		endcase
		return f;
	endfunction

	task automatic refresh_hot_flows();
		for (int i = 0; i < HOT_FLOWS; i++) begin
			hot_flows[i].src = $urandom;
			hot_flows[i].dst = $urandom;
		end
	endtask

	// Clock.
	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Flow driver: offers queued flows, waiting a drawn number of cycles after
	// each accepted request, and predicts the result of every accepted flow.
	always @(posedge clk or negedge arst_n) begin : drive_flows
		int unsigned tx_wait;
		flow_t f;
		if (!arst_n) begin
			flow_ch.valid <= 1'b0;
			flow_ch.src_addr <= '0;
			flow_ch.dst_addr <= '0;
			tx_wait = 0;
		end else begin
			if (flow_ch.valid && flow_ch.ready) begin
				sketch_update(flow_ch.src_addr, flow_ch.dst_addr);
				tx_wait = $urandom_range(tx_gap_max, 0);
			end
			if (!flow_ch.valid || flow_ch.ready) begin
				if (tx_wait == 0 && pending_flows.size() > 0) begin
					f = pending_flows.pop_front();
					flow_ch.valid <= 1'b1;
					flow_ch.src_addr <= f.src;
					flow_ch.dst_addr <= f.dst;
				end else begin
					// Idle cycles carry junk addresses that must be ignored.
					flow_ch.valid <= 1'b0;
					flow_ch.src_addr <= $urandom;
					flow_ch.dst_addr <= $urandom;
					if (tx_wait > 0) begin
						tx_wait--;
					end
				end
			end
		end
	end

	// Result monitor: checks each accepted request against the oldest report
	// and stalls for a drawn number of cycles after it, or for a long hold.
	always @(posedge clk or negedge arst_n) begin : watch_results
		int unsigned rx_wait;
		int unsigned rx_hold_left;
		int unsigned rx_holds_done;
		flow_report_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			rx_wait = 0;
			rx_hold_left = 0;
			rx_holds_done = 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (report_q.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected result, expected none, actual estimate %h",
						$time, result_ch.estimate);
				end else begin
					want = report_q.pop_front();
					check_field("estimate", want.estimate, result_ch.estimate);
					check_field("new_leader", 32'(want.new_leader), 32'(result_ch.new_leader));
					check_field("leader_count", want.leader_count, result_ch.leader_count);
					check_field("leader_src", want.leader_src, result_ch.leader_src);
					check_field("leader_dst", want.leader_dst, result_ch.leader_dst);
				end
				rx_wait = $urandom_range(rx_gap_max, 0);
			end
			if (rx_holds_done != rx_holds_asked) begin
				rx_holds_done++;
				rx_hold_left = LONG_HOLD_CYCLES;
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				result_ch.ready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Stimulus sequence.
	initial begin
		int unsigned gap_plan [6][2];
		flow_t f;
		tx_gap_max = 0;
		rx_gap_max = 0;
		rx_holds_asked = 0;
		mismatch_count = 0;
		for (int i = 0; i < ROW_DEPTH; i++) begin
			sum_cnt[i] = '0;
			diff_cnt[i] = '0;
			xor_cnt[i] = '0;
		end
		lead_count = '0;
		lead_src = '0;
		lead_dst = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed flows, back to back: the first flow always leads, a repeat
		// hits the same counters at once, the address extremes and wrapping
		// hashes, an estimate equal to the leader count, and ties in the rows.
		queue_flow(32'h0000_0000, 32'h0000_0000);
		queue_flow(32'h0000_0000, 32'h0000_0000);
		queue_flow(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_flow(32'hFFFF_FFFF, 32'h0000_0000);
		queue_flow(32'h0000_0000, 32'hFFFF_FFFF);
		queue_flow(32'h8000_0000, 32'h8000_0000);
		queue_flow(32'h0000_0100, 32'h0000_0200);
		queue_flow(32'h0000_0100, 32'h0000_0200);
		queue_flow(32'h0000_0100, 32'h0000_0200);
		queue_flow(32'h0000_0001, 32'h0000_0000);
		queue_flow(32'h0000_0000, 32'h0000_0001);
		queue_flow(32'hAAAA_AAAA, 32'h5555_5555);
		queue_flow(32'h5555_5555, 32'hAAAA_AAAA);
		queue_flow(32'h1234_5678, 32'h9ABC_DEF0);
		queue_flow(32'h0000_0100, 32'h0000_0200);
		while (pending_flows.size() != 0 || report_q.size() != 0) @(negedge clk);

		// Long receiver hold while the sender keeps offering, so that the
		// pipeline fills and the flow channel stalls.
		refresh_hot_flows();
		rx_holds_asked++;
		for (int i = 0; i < LONG_HOLD_FLOWS; i++) begin
			f = random_flow();
			pending_flows.push_back(f);
		end
		while (pending_flows.size() != 0 || report_q.size() != 0) @(negedge clk);

		// Random phases with different idle patterns on each side.
		gap_plan = '{'{0, 0}, '{15, 0}, '{0, 15}, '{15, 15}, '{3, 3}, '{0, 0}};
		for (int p = 0; p < 6; p++) begin
			tx_gap_max = gap_plan[p][0];
			rx_gap_max = gap_plan[p][1];
			if (p % 2 == 0) begin
				refresh_hot_flows();
			end
			for (int i = 0; i < PHASE_FLOWS; i++) begin
				f = random_flow();
				pending_flows.push_back(f);
			end
			while (pending_flows.size() != 0) @(negedge clk);
			// Once in the run the sender pauses until every result is back.
			if (p == 3) begin
				while (flow_ch.valid || report_q.size() != 0) @(negedge clk);
			end
		end

		while (flow_ch.valid || report_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
